// File: rtl/circular_sg_fifo_dma_walker_defines.svh
// Assertion macros used by the walker back end (csgw_back).
`ifndef CIRCULAR_SG_FIFO_DMA_WALKER_DEFINES_SVH
`define CIRCULAR_SG_FIFO_DMA_WALKER_DEFINES_SVH

// Check a condition on every clock edge outside reset.
`define CSGW_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check that a condition implies another in the same cycle.
`define CSGW_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`endif

// File: rtl/csgw_pkg.sv
// Package with command, result types and codes for the ring walker.
`timescale 1ns / 1ps
package csgw_pkg;

  // Result status codes
  localparam logic [2:0] ST_CHUNK    = 3'd0;
  localparam logic [2:0] ST_PTR_ONLY = 3'd1;
  localparam logic [2:0] ST_EMPTY    = 3'd2;
  localparam logic [2:0] ST_RANGE    = 3'd3;
  localparam logic [2:0] ST_PAST_END = 3'd4;
  localparam logic [2:0] ST_OVERFLOW = 3'd5;

  // Input kinds
  localparam logic KIND_XFER = 1'b0;
  localparam logic KIND_LOAD = 1'b1;

  // Configuration register indexes
  localparam logic [1:0] REG_TABLE_ADDR = 2'd0;
  localparam logic [1:0] REG_LAST_ENTRY = 2'd1;
  localparam logic [1:0] REG_RELAXED    = 2'd2;

  localparam int ENTRY_SHIFT = 3;  // 8-byte table entries

  typedef struct packed {
    logic        kind;
    logic [1:0]  fifo_number;
    logic        to_memory;
    logic [12:0] byte_length;
    logic [31:0] window_start;
    logic [31:0] window_limit;
    logic [31:0] pointer_value;
  } cmd_t;

endpackage

// File: rtl/circular_sg_fifo_dma_walker.sv
// Top level of the circular-window scatter-gather DMA walker.
`timescale 1ns / 1ps
// Walks DSP FIFO rings over a paged byte space. A load word (tuser 1) sets
// one FIFO's base, end and pointer; with a table set, a transfer word splits
// byte_length at ring wrap and page ends and gives one result word per chunk.
// A transfer may first need a modulo (a 33-step restoring divider, used to
// fold an out-of-window pointer and for pointer-only advance); it then plans
// its chunks, closes the plan and emits the chunks one by one. Output
// back-pressure can stall this. A two-word queue lets the input side run ahead.
module circular_sg_fifo_dma_walker #(
  parameter int FIFOS_PER_DIRECTION = 4,
  parameter int PAGE_BYTES          = 4096,
  parameter int MAX_CHUNKS          = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_data,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // fifo_number, to_memory, byte_length, window_start, window_limit, pointer_value
  input  logic [111:0] s_axis_tdata,
  // kind
  input  logic [0:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // entry_address, page_offset, byte_count, write_dir, new_pointer, zero fill
  output logic [95:0]  m_axis_tdata,
  // status
  output logic [2:0]   m_axis_tuser,
  output logic         m_axis_tlast
);

  logic           push;
  logic           full;
  logic           q_valid;
  logic           q_pop;
  csgw_pkg::cmd_t push_cmd;
  csgw_pkg::cmd_t q_cmd;

  assign cfg_ready = 1'b1;

  csgw_front #(.FIFOS_PER_DIRECTION(FIFOS_PER_DIRECTION)) u_front (
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .push(push), .push_cmd(push_cmd), .full(full)
  );

  csgw_queue u_queue (
    .clk(clk), .rst(rst), .push(push), .push_cmd(push_cmd), .full(full),
    .pop_valid(q_valid), .pop(q_pop), .pop_cmd(q_cmd)
  );

  csgw_back #(
    .FIFOS_PER_DIRECTION(FIFOS_PER_DIRECTION),
    .PAGE_BYTES(PAGE_BYTES),
    .MAX_CHUNKS(MAX_CHUNKS)
  ) u_back (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid && cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .q_valid(q_valid), .q_pop(q_pop), .q_cmd(q_cmd),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast)
  );

endmodule

// File: rtl/csgw_front.sv
// Front end: accept input words, drop bad FIFO numbers, queue commands.
`timescale 1ns / 1ps
module csgw_front #(
  parameter int FIFOS_PER_DIRECTION = 4
) (
  input  logic                rst,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [111:0]        s_axis_tdata,
  input  logic [0:0]          s_axis_tuser,
  output logic                push,
  output csgw_pkg::cmd_t      push_cmd,
  input  logic                full
);

  logic fn_ok;

  // Unpack the word
  always_comb begin
    push_cmd.kind          = s_axis_tuser[0];
    push_cmd.fifo_number   = s_axis_tdata[1:0];
    push_cmd.to_memory     = s_axis_tdata[2];
    push_cmd.byte_length   = s_axis_tdata[15:3];
    push_cmd.window_start  = s_axis_tdata[47:16];
    push_cmd.window_limit  = s_axis_tdata[79:48];
    push_cmd.pointer_value = s_axis_tdata[111:80];
  end

  // Words for a FIFO that does not exist are taken and dropped
  assign fn_ok         = (32'(s_axis_tdata[1:0]) < 32'(FIFOS_PER_DIRECTION));
  assign s_axis_tready = !full;
  assign push          = s_axis_tvalid && s_axis_tready && fn_ok && !rst;

endmodule

// File: rtl/csgw_queue.sv
// Two-entry command queue between front and back end.
`timescale 1ns / 1ps
module csgw_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  csgw_pkg::cmd_t push_cmd,
  output logic           full,
  output logic           pop_valid,
  input  logic           pop,
  output csgw_pkg::cmd_t pop_cmd
);

  localparam int DEPTH = 2;

  csgw_pkg::cmd_t mem [DEPTH];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full      = (count == 2'(DEPTH));
  assign pop_valid = (count != 2'd0);
  assign pop_cmd   = mem[rd_ptr];

  // Store on push
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop && pop_valid) rd_ptr <= !rd_ptr;
      count <= count + 2'(push) - 2'(pop && pop_valid);
    end
  end

endmodule

// File: rtl/csgw_back.sv
// Back end: window state, modulo unit, chunk planner and result register.
`timescale 1ns / 1ps
`include "circular_sg_fifo_dma_walker_defines.svh"
module csgw_back #(
  parameter int FIFOS_PER_DIRECTION = 4,
  parameter int PAGE_BYTES          = 4096,
  parameter int MAX_CHUNKS          = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_valid,
  input  logic [1:0]     cfg_index,
  input  logic [31:0]    cfg_data,
  input  logic           q_valid,
  output logic           q_pop,
  input  csgw_pkg::cmd_t q_cmd,
  output logic           m_axis_tvalid,
  input  logic           m_axis_tready,
  output logic [95:0]    m_axis_tdata,
  output logic [2:0]     m_axis_tuser,
  output logic           m_axis_tlast
);

  localparam int SLOTS     = 2 * FIFOS_PER_DIRECTION;
  localparam int SLOT_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int PB        = $clog2(PAGE_BYTES);
  localparam int ENTRY_W   = 32 - PB;
  localparam int N_W       = $clog2(MAX_CHUNKS + 1);
  localparam int DIV_STEPS = 33;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_DIVD  = 3'd3;
  localparam logic [2:0] S_PTR   = 3'd4;
  localparam logic [2:0] S_PLAN  = 3'd5;
  localparam logic [2:0] S_EMIT  = 3'd6;

  logic [2:0]  state;
  logic [31:0] table_address;
  logic [15:0] table_last_entry;
  logic        relaxed_wrap;

  logic [31:0] base_q [SLOTS];
  logic [31:0] end_q  [SLOTS];
  logic [31:0] cur_q  [SLOTS];

  logic [SLOT_W-1:0] slot;
  logic [31:0] base;
  logic [31:0] lim;
  logic [31:0] stored;
  logic [31:0] cur;
  logic [12:0] len;
  logic        dir;
  logic [31:0] p;
  logic [12:0] rem;
  logic [N_W-1:0] nchunks;

  logic [32:0] div_r;
  logic [32:0] div_n;
  logic [31:0] div_d;
  logic [5:0]  div_cnt;
  logic        div_for_ptr;

  logic        out_free;
  logic [SLOT_W-1:0] cmd_slot;
  logic [32:0] div_shift;
  logic [31:0] to_end;
  logic [PB:0] in_page;
  logic [12:0] take;
  logic [31:0] p_adv;
  logic [31:0] p_next;
  logic [ENTRY_W-1:0] entry;
  logic [31:0] eaddr;
  logic [31:0] raised;

  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign q_pop    = (state == S_IDLE) && q_valid;
  assign cmd_slot = q_cmd.to_memory
                  ? SLOT_W'(32'(FIFOS_PER_DIRECTION) + 32'(q_cmd.fifo_number))
                  : SLOT_W'(q_cmd.fifo_number);

  // Chunk size: bounded by ring end, bytes left and page end
  always_comb begin
    to_end  = lim - p;
    in_page = (PB+1)'(PAGE_BYTES) - {1'b0, p[PB-1:0]};
    take    = rem;
    if (to_end < 32'(take)) take = 13'(to_end);
    if (32'(in_page) < 32'(take)) take = 13'(in_page);
    p_adv   = p + 32'(take);
    p_next  = (p_adv == lim) ? base : p_adv;
    entry   = p[31:PB];
    eaddr   = table_address + (32'(entry) << csgw_pkg::ENTRY_SHIFT);
    raised  = (cur < base) ? base : cur;
  end

  // Restoring divider step
  assign div_shift = {div_r[31:0], div_n[32]};

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      table_address    <= 32'd0;
      table_last_entry <= 16'd0;
      relaxed_wrap     <= 1'b1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        csgw_pkg::REG_TABLE_ADDR: table_address    <= cfg_data;
        csgw_pkg::REG_LAST_ENTRY: table_last_entry <= cfg_data[15:0];
        csgw_pkg::REG_RELAXED:    relaxed_wrap     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    logic tvalid_next;
    if (rst) begin
      state         <= S_IDLE;
      m_axis_tvalid <= 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
        base_q[i] <= 32'd0;
        end_q[i]  <= 32'd0;
        cur_q[i]  <= 32'd0;
      end
    end else begin
      // Drop the result word once it is taken
      tvalid_next = m_axis_tvalid && !m_axis_tready;
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            if (q_cmd.kind == csgw_pkg::KIND_LOAD) begin
              base_q[cmd_slot] <= q_cmd.window_start;
              end_q[cmd_slot]  <= q_cmd.window_limit;
              cur_q[cmd_slot]  <= q_cmd.pointer_value;
            end else begin
              slot   <= cmd_slot;
              base   <= base_q[cmd_slot];
              lim    <= end_q[cmd_slot];
              stored <= cur_q[cmd_slot];
              cur    <= cur_q[cmd_slot];
              len    <= q_cmd.byte_length;
              dir    <= q_cmd.to_memory;
              state  <= S_CHECK;
            end
          end
        end
        S_CHECK: begin
          if (relaxed_wrap) begin
            if (lim <= base) begin
              if (out_free) begin
                tvalid_next   = 1'b1;
                m_axis_tuser  <= csgw_pkg::ST_EMPTY;
                m_axis_tdata  <= {6'd0, stored, dir, 13'd0, 12'd0, 32'd0};
                m_axis_tlast  <= 1'b1;
                state         <= S_IDLE;
              end
            end else if (cur >= lim) begin
              div_r       <= 33'd0;
              div_n       <= {1'b0, cur - base};
              div_d       <= lim - base;
              div_cnt     <= 6'd0;
              div_for_ptr <= 1'b0;
              state       <= S_DIV;
            end else begin
              cur   <= raised;
              state <= S_PTR;
            end
          end else begin
            if (raised >= lim) begin
              if (out_free) begin
                tvalid_next   = 1'b1;
                m_axis_tuser  <= csgw_pkg::ST_PAST_END;
                m_axis_tdata  <= {6'd0, stored, dir, 13'd0, 12'd0, 32'd0};
                m_axis_tlast  <= 1'b1;
                state         <= S_IDLE;
              end
            end else begin
              cur   <= raised;
              state <= S_PTR;
            end
          end
        end
        S_DIV: begin
          div_r   <= (div_shift >= {1'b0, div_d}) ? div_shift - {1'b0, div_d} : div_shift;
          div_n   <= {div_n[31:0], 1'b0};
          div_cnt <= div_cnt + 6'd1;
          if (div_cnt == 6'(DIV_STEPS - 1)) state <= S_DIVD;
        end
        S_DIVD: begin
          if (!div_for_ptr) begin
            cur   <= base + div_r[31:0];
            state <= S_PTR;
          end else if (out_free) begin
            cur_q[slot]   <= base + div_r[31:0];
            tvalid_next   = 1'b1;
            m_axis_tuser  <= csgw_pkg::ST_PTR_ONLY;
            m_axis_tdata  <= {6'd0, base + div_r[31:0], dir, len, 12'd0, 32'd0};
            m_axis_tlast  <= 1'b1;
            state         <= S_IDLE;
          end
        end
        S_PTR: begin
          if (table_address == 32'd0) begin
            div_r       <= 33'd0;
            div_n       <= {1'b0, cur - base} + 33'(len);
            div_d       <= lim - base;
            div_cnt     <= 6'd0;
            div_for_ptr <= 1'b1;
            state       <= S_DIV;
          end else if (len == 13'd0) begin
            state <= S_IDLE;
          end else begin
            p       <= cur;
            rem     <= len;
            nchunks <= '0;
            state   <= S_PLAN;
          end
        end
        S_PLAN: begin
          if (rem == 13'd0) begin
            p     <= cur;
            rem   <= len;
            state <= S_EMIT;
          end else if (nchunks == N_W'(MAX_CHUNKS)) begin
            if (out_free) begin
              tvalid_next   = 1'b1;
              m_axis_tuser  <= csgw_pkg::ST_OVERFLOW;
              m_axis_tdata  <= {6'd0, stored, dir, 13'd0, 12'd0, 32'd0};
              m_axis_tlast  <= 1'b1;
              state         <= S_IDLE;
            end
          end else begin
            nchunks <= nchunks + N_W'(1);
            rem     <= rem - take;
            p       <= p_next;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            tvalid_next = 1'b1;
            if (32'(entry) > 32'(table_last_entry)) begin
              m_axis_tuser <= csgw_pkg::ST_RANGE;
              m_axis_tdata <= {6'd0, cur_q[slot], dir, 13'd0, 12'(p[PB-1:0]), eaddr};
              m_axis_tlast <= 1'b1;
              state        <= S_IDLE;
            end else begin
              cur_q[slot]  <= p_next;
              m_axis_tuser <= csgw_pkg::ST_CHUNK;
              m_axis_tdata <= {6'd0, p_next, dir, take, 12'(p[PB-1:0]), eaddr};
              m_axis_tlast <= (rem == take);
              rem          <= rem - take;
              p            <= p_next;
              if (rem == take) state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
      m_axis_tvalid <= tvalid_next;
    end
  end

  `CSGW_ASSERT_IMPLY(a_status_last, m_axis_tvalid && m_axis_tuser != csgw_pkg::ST_CHUNK, m_axis_tlast, "non-chunk result without last")
  `CSGW_ASSERT_IMPLY(a_div_cnt, state == S_DIV, div_cnt < 6'(DIV_STEPS), "divider ran past its steps")
  `CSGW_ASSERT_IMPLY(a_plan_cnt, state == S_PLAN, nchunks <= N_W'(MAX_CHUNKS), "chunk count past limit")
  `CSGW_ASSERT_IMPLY(a_pop_idle, q_pop, state == S_IDLE, "command taken while busy")

endmodule

// File: sim/circular_sg_fifo_dma_walker_checker.sv
// Checker: predicts ring walker results and compares the output stream.
`timescale 1ns / 1ps
module circular_sg_fifo_dma_walker_checker
  import csgw_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_valid,
  input  logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_data,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [111:0] s_axis_tdata,
  input  logic [0:0]   s_axis_tuser,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [95:0]  m_axis_tdata,
  input  logic [2:0]   m_axis_tuser,
  input  logic         m_axis_tlast,
  output int           mismatches,
  output int           pending
);

  localparam int FIFOS = 4;
  localparam int PAGE = 4096;
  localparam int CHUNKS_MAX = 16;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] entry_address;
    logic [11:0] page_offset;
    logic [12:0] byte_count;
    logic        write_dir;
    logic [31:0] new_pointer;
    logic        last;
  } walk_word_t;

  // shadow copy of block state and registers
  logic [31:0] ring_base [2*FIFOS];
  logic [31:0] ring_end  [2*FIFOS];
  logic [31:0] ring_ptr  [2*FIFOS];
  logic [31:0] table_addr;
  logic [15:0] last_entry;
  logic        relaxed;

  walk_word_t expected_words[$];

  function automatic walk_word_t mk_word(logic [2:0] st, logic [31:0] ea, logic [11:0] po,
                                         logic [12:0] bc, logic d, logic [31:0] np,
                                         logic lst);
    walk_word_t w;
    w.status = st; w.entry_address = ea; w.page_offset = po; w.byte_count = bc;
    w.write_dir = d; w.new_pointer = np; w.last = lst;
    return w;
  endfunction

  // Work out the words that one accepted command causes
  task automatic walk_ring(cmd_t c);
    logic [2:0]  slot;
    logic [31:0] base, lim, stored, cur, p, rem, take, in_page, entry, ea;
    logic [63:0] off;
    logic [31:0] cstart [CHUNKS_MAX];
    logic [31:0] clen [CHUNKS_MAX];
    int n;
    slot = {c.to_memory, c.fifo_number};
    if (c.kind == KIND_LOAD) begin
      ring_base[slot] = c.window_start;
      ring_end[slot] = c.window_limit;
      ring_ptr[slot] = c.pointer_value;
      return;
    end
    base = ring_base[slot];
    lim = ring_end[slot];
    stored = ring_ptr[slot];
    cur = stored;
    if (relaxed) begin
      if (lim <= base) begin
        expected_words.push_back(mk_word(ST_EMPTY, '0, '0, '0, c.to_memory, stored, 1'b1));
        return;
      end
      if (cur >= lim) cur = base + (cur - base) % (lim - base);
      if (cur < base) cur = base;
    end else begin
      if (cur < base) cur = base;
      if (cur >= lim) begin
        expected_words.push_back(mk_word(ST_PAST_END, '0, '0, '0, c.to_memory, stored,
                                         1'b1));
        return;
      end
    end
    // no table: advance the pointer only
    if (table_addr == 0) begin
      off = 64'(cur - base) + 64'(c.byte_length);
      off = off % 64'(lim - base);
      cur = base + off[31:0];
      ring_ptr[slot] = cur;
      expected_words.push_back(mk_word(ST_PTR_ONLY, '0, '0, c.byte_length, c.to_memory,
                                       cur, 1'b1));
      return;
    end
    // split at ring wrap and page ends
    n = 0;
    p = cur;
    rem = 32'(c.byte_length);
    while (rem > 0) begin
      if (n == CHUNKS_MAX) begin
        expected_words.push_back(mk_word(ST_OVERFLOW, '0, '0, '0, c.to_memory, stored,
                                         1'b1));
        return;
      end
      take = lim - p;
      if (take > rem) take = rem;
      in_page = PAGE - (p % PAGE);
      if (take > in_page) take = in_page;
      cstart[n] = p;
      clen[n] = take;
      n++;
      rem -= take;
      p += take;
      if (p == lim) p = base;
    end
    for (int i = 0; i < n; i++) begin
      entry = cstart[i] / PAGE;
      ea = table_addr + (entry << ENTRY_SHIFT);
      if (entry > 32'(last_entry)) begin
        expected_words.push_back(mk_word(ST_RANGE, ea, cstart[i][11:0], '0, c.to_memory,
                                         ring_ptr[slot], 1'b1));
        return;
      end
      cur = cstart[i] + clen[i];
      if (cur == lim) cur = base;
      ring_ptr[slot] = cur;
      expected_words.push_back(mk_word(ST_CHUNK, ea, cstart[i][11:0], clen[i][12:0],
                                       c.to_memory, cur, i == n - 1));
    end
  endtask

  // Watch all three channels on every edge
  always @(posedge clk) begin
    walk_word_t got, exp_w;
    cmd_t c;
    if (rst) begin
      for (int i = 0; i < 2 * FIFOS; i++) begin
        ring_base[i] = 0; ring_end[i] = 0; ring_ptr[i] = 0;
      end
      table_addr = 0;
      last_entry = 0;
      relaxed = 1'b1;
      expected_words.delete();
      mismatches = 0;
    end else begin
      // compare an output word with the oldest expectation
      if (m_axis_tvalid && m_axis_tready) begin
        got = mk_word(m_axis_tuser, m_axis_tdata[31:0], m_axis_tdata[43:32],
                      m_axis_tdata[56:44], m_axis_tdata[57], m_axis_tdata[89:58],
                      m_axis_tlast);
        if (expected_words.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected word: st=%0d ea=%h po=%h bc=%0d dir=%b np=%h last=%b",
                     got.status, got.entry_address, got.page_offset, got.byte_count,
                     got.write_dir, got.new_pointer, got.last);
        end else begin
          exp_w = expected_words.pop_front();
          if (got != exp_w) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch exp: st=%0d ea=%h po=%h bc=%0d dir=%b np=%h last=%b",
                       exp_w.status, exp_w.entry_address, exp_w.page_offset,
                       exp_w.byte_count, exp_w.write_dir, exp_w.new_pointer, exp_w.last);
              $display("         got: st=%0d ea=%h po=%h bc=%0d dir=%b np=%h last=%b",
                       got.status, got.entry_address, got.page_offset, got.byte_count,
                       got.write_dir, got.new_pointer, got.last);
            end
          end
        end
      end
      // register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_TABLE_ADDR: table_addr = cfg_data;
          REG_LAST_ENTRY: last_entry = cfg_data[15:0];
          REG_RELAXED:    relaxed = cfg_data[0];
          default: ;
        endcase
      end
      // accepted command word
      if (s_axis_tvalid && s_axis_tready) begin
        c.kind = s_axis_tuser[0];
        c.fifo_number = s_axis_tdata[1:0];
        c.to_memory = s_axis_tdata[2];
        c.byte_length = s_axis_tdata[15:3];
        c.window_start = s_axis_tdata[47:16];
        c.window_limit = s_axis_tdata[79:48];
        c.pointer_value = s_axis_tdata[111:80];
        walk_ring(c);
      end
    end
    pending = expected_words.size();
  end

endmodule

// File: sim/tb_circular_sg_fifo_dma_walker.sv
// Testbench top: stimulus, idling phases and verdict for the ring walker.
`timescale 1ns / 1ps
module tb_circular_sg_fifo_dma_walker;
  import csgw_pkg::*;

  logic         clk;
  logic         rst;
  logic         cfg_valid;
  logic         cfg_ready;
  logic [1:0]   cfg_index;
  logic [31:0]  cfg_data;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [111:0] s_axis_tdata;
  logic [0:0]   s_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [95:0]  m_axis_tdata;
  logic [2:0]   m_axis_tuser;
  logic         m_axis_tlast;
  int           mismatches;
  int           pending;

  int   idle_mode;    // 0 none, 1 sender, 2 receiver, 3 both
  logic hold_req;

  circular_sg_fifo_dma_walker u_top (.*);

  circular_sg_fifo_dma_walker_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

  // Receiver: random stalls per phase, plus one long hold-off
  initial begin
    int hold_left;
    logic hold_taken;
    hold_left = 0;
    hold_taken = 1'b0;
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (idle_mode == 2)
        m_axis_tready <= $urandom_range(99) >= 57;
      else if (idle_mode == 3)
        m_axis_tready <= $urandom_range(99) >= 27;
      else
        m_axis_tready <= 1'b1;
    end
  end

  function automatic cmd_t mk_cmd(logic k, logic [1:0] fn, logic dir, logic [12:0] len,
                                  logic [31:0] ws, logic [31:0] wl, logic [31:0] pv);
    cmd_t c;
    c.kind = k; c.fifo_number = fn; c.to_memory = dir; c.byte_length = len;
    c.window_start = ws; c.window_limit = wl; c.pointer_value = pv;
    return c;
  endfunction

  // Offer one command word and wait until it is taken
  task automatic send_cmd(cmd_t c);
    int gap;
    gap = 0;
    if ((idle_mode == 1 && $urandom_range(99) < 57) ||
        (idle_mode == 3 && $urandom_range(99) < 27))
      gap = $urandom_range(1, 5);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= c.kind;
    s_axis_tdata <= {c.pointer_value, c.window_limit, c.window_start, c.byte_length,
                     c.to_memory, c.fifo_number};
    @(negedge clk);
    while (!s_axis_tready) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic load_ring(logic dir, logic [1:0] fn, logic [31:0] ws, logic [31:0] wl,
                           logic [31:0] pv);
    send_cmd(mk_cmd(KIND_LOAD, fn, dir, 13'($urandom_range(8191)), ws, wl, pv));
  endtask

  task automatic xfer(logic dir, logic [1:0] fn, logic [12:0] len);
    send_cmd(mk_cmd(KIND_XFER, fn, dir, len, $urandom, $urandom, $urandom));
  endtask

  // Drain the block, then let any result-free word finish
  task automatic drain;
    s_axis_tvalid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (150) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    while (!cfg_ready) @(negedge clk);
    @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_regs(logic [31:0] ta, logic [31:0] le, logic rw);
    write_reg(REG_TABLE_ADDR, ta);
    write_reg(REG_LAST_ENTRY, le);
    write_reg(REG_RELAXED, {31'd0, rw});
  endtask

  // Random mix: mostly sane windows with random content, some noise
  task automatic random_cmds(int count);
    logic [31:0] base, size, ptr;
    logic [12:0] len;
    int r;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < 25) begin
        r = $urandom_range(9);
        if (r == 0)
          load_ring(1'($urandom), 2'($urandom), $urandom, $urandom, $urandom);
        else begin
          base = (r == 1) ? 32'($urandom) : 32'($urandom_range(0, 32'h3FFFF));
          size = (r < 4) ? 32'($urandom_range(1, 64)) : 32'($urandom_range(64, 20000));
          ptr = ($urandom_range(3) == 0) ? 32'($urandom_range(0, base + 4 * size))
                                         : base + 32'($urandom_range(0, size - 1));
          load_ring(1'($urandom), 2'($urandom), base, base + size, ptr);
        end
      end else begin
        r = $urandom_range(19);
        len = (r == 0) ? 13'd0 : (r == 1) ? 13'd4096 : (r == 2) ? 13'd1
                              : 13'($urandom_range(0, 4096));
        xfer(1'($urandom), 2'($urandom), len);
      end
    end
  endtask

  initial begin
    idle_mode = 0;
    hold_req = 1'b0;
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = REG_TABLE_ADDR;
    cfg_data = 32'd0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = KIND_XFER;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Paged walk, relaxed wrap
    set_regs(32'h0000_1000, 32'h0000_FFFF, 1'b1);
    load_ring(1'b0, 2'd0, 32'h2000, 32'h6000, 32'h1000);         // pointer below base
    xfer(1'b0, 2'd0, 13'd0);                                     // zero length
    xfer(1'b0, 2'd0, 13'd100);
    xfer(1'b0, 2'd0, 13'd4096);                                  // page split
    load_ring(1'b1, 2'd3, 32'h3F00, 32'h4100, 32'h9000);         // past end, fold
    xfer(1'b1, 2'd3, 13'd700);                                   // ring wrap
    load_ring(1'b0, 2'd1, 32'h100, 32'h100, 32'h100);            // empty window
    xfer(1'b0, 2'd1, 13'd10);
    load_ring(1'b0, 2'd2, 32'h0, 32'h10, 32'h0);                 // tiny ring
    xfer(1'b0, 2'd2, 13'd4096);                                  // overflow
    load_ring(1'b1, 2'd0, 32'h0FFF_F800, 32'h1000_1000, 32'h0FFF_F800);
    xfer(1'b1, 2'd0, 13'd4096);                                  // entry out of range
    load_ring(1'b1, 2'd1, 32'hFFFF_F000, 32'hFFFF_FFFF, 32'hFFFF_FFFE);
    xfer(1'b1, 2'd1, 13'd4096);
    random_cmds(70);
    drain();

    // Pointer-only advance
    idle_mode = 1;
    set_regs(32'h0, 32'h0000_0010, 1'b1);
    xfer(1'b0, 2'd0, 13'd4096);
    xfer(1'b0, 2'd1, 13'd7);
    load_ring(1'b0, 2'd3, 32'h1000, 32'h1010, 32'hFFFF_FFFF);
    xfer(1'b0, 2'd3, 13'd4095);
    random_cmds(70);
    drain();

    // Strict wrap with a short table
    idle_mode = 2;
    set_regs(32'h8000_0000, 32'h0000_0003, 1'b0);
    xfer(1'b0, 2'd1, 13'd10);                                    // empty window, strict
    load_ring(1'b1, 2'd2, 32'h1000, 32'h5000, 32'h7000);         // past end, strict
    xfer(1'b1, 2'd2, 13'd20);
    load_ring(1'b1, 2'd2, 32'h1000, 32'h5000, 32'h0);
    xfer(1'b1, 2'd2, 13'd4096);
    random_cmds(80);
    drain();

    // Table near the top of the space, with a long receiver hold-off
    idle_mode = 3;
    set_regs(32'hFFFF_FFF8, 32'h0000_0000, 1'b1);
    hold_req <= 1'b1;
    random_cmds(90);
    drain();

    // Table at address 0x8 in strict mode, no idling
    idle_mode = 0;
    set_regs(32'h0000_0008, 32'h0000_FFFF, 1'b0);
    random_cmds(80);
    drain();

    if (mismatches == 0 && pending == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
